// ===== sv/lpc_pkg.sv =====
// Shared types and constants for the Langford pairing counter.
// No dependencies; compiled first.
`default_nettype none

package lpc_pkg;

    localparam int DEF_MAX_PAIRS    = 16;
    localparam int DEF_PREFIX_PAIRS = 3;

    localparam int POS_W   = 5;    // input position field width
    localparam int NCFG_W  = 5;    // pair_count register width
    localparam int COUNT_W = 32;   // solution count width
    localparam int PFX_MAX = 3;    // prefix fields present on the input channel
    localparam int PFX_IDX_W = 2;

    localparam logic [NCFG_W-1:0] PAIR_COUNT_RESET = NCFG_W'(16);
    localparam logic [NCFG_W-1:0] PAIR_COUNT_MIN   = NCFG_W'(4);

    typedef struct packed {
        logic [NCFG_W-1:0]              n;
        logic [PFX_MAX-1:0][POS_W-1:0]  pos;   // pos[0] is pair n
    } t_task;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               rejected;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/lpc_in_if.sv =====
// Input task channel: three prefix positions with valid/ready.
// Depends on lpc_pkg.
`default_nettype none

interface lpc_in_if import lpc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] top_pair_pos;
    logic [POS_W-1:0] second_pair_pos;
    logic [POS_W-1:0] third_pair_pos;

    modport source (output valid, top_pair_pos, second_pair_pos, third_pair_pos,
                    input ready);
    modport sink   (input valid, top_pair_pos, second_pair_pos, third_pair_pos,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/lpc_out_if.sv =====
// Result channel: solution count and reject flag with valid/ready.
// Depends on lpc_pkg.
`default_nettype none

interface lpc_out_if import lpc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] solution_count;
    logic               prefix_rejected;

    modport source (output valid, solution_count, prefix_rejected, input ready);
    modport sink   (input valid, solution_count, prefix_rejected, output ready);
endinterface

`default_nettype wire

// ===== sv/lpc_cfg_if.sv =====
// Configuration write channel for the pair_count register.
// Depends on lpc_pkg.
`default_nettype none

interface lpc_cfg_if import lpc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [NCFG_W-1:0] pair_count;

    modport source (output valid, pair_count, input ready);
    modport sink   (input valid, pair_count, output ready);
endinterface

`default_nettype wire

// ===== sv/lpc_engine.sv =====
// Backtracking search engine: slot occupancy and pair position memories
// plus the sequencer that places, scans and lifts pairs. Depends on lpc_pkg.
`default_nettype none

module lpc_engine import lpc_pkg::*; #(
    parameter int MAX_PAIRS    = DEF_MAX_PAIRS,
    parameter int PREFIX_PAIRS = DEF_PREFIX_PAIRS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_task   i_task,
    output logic         o_idle,
    input  wire logic    i_res_ready,
    output logic         o_done,
    output t_result      o_result
);

    localparam int SLOTS = 2 * MAX_PAIRS;
    localparam int SA_W  = $clog2(SLOTS);
    localparam int PA_W  = $clog2(MAX_PAIRS);
    localparam int PV_W  = ($clog2(SLOTS + 1) > POS_W) ? $clog2(SLOTS + 1) : POS_W;
    localparam int LV_W  = $clog2(MAX_PAIRS + 1);
    localparam int DEPTH = (PREFIX_PAIRS > PFX_MAX) ? PFX_MAX :
                           ((PREFIX_PAIRS < 1) ? 1 : PREFIX_PAIRS);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_PF_RD, S_PF_CHK, S_PUT_A, S_PUT_B, S_LVL, S_POS,
        S_LIFT_A, S_LIFT_B, S_SCAN_RD, S_SCAN_CHK, S_DONE
    } t_state;

    t_state                      r_state;
    logic [NCFG_W-1:0]           r_n;
    logic [PFX_MAX-1:0][POS_W-1:0] r_pos_in;
    logic [PFX_IDX_W-1:0]        r_idx;
    logic [LV_W-1:0]             r_top;
    logic [LV_W-1:0]             r_level;
    logic [LV_W-1:0]             r_k;
    logic [PV_W-1:0]             r_p;
    logic [PV_W-1:0]             r_q;
    logic [SA_W-1:0]             r_clr;
    logic [COUNT_W-1:0]          r_cnt;
    logic                        r_rej;
    logic                        r_in_search;

    // memories, registered read
    logic                        r_slot_mem [SLOTS];
    logic [PV_W-1:0]             r_pos_mem  [MAX_PAIRS];
    logic                        r_slot_rd_a;
    logic                        r_slot_rd_b;
    logic [PV_W-1:0]             r_pos_rd;

    logic                        slot_we;
    logic [SA_W-1:0]             slot_wa;
    logic                        slot_wd;
    logic [SA_W-1:0]             slot_ra_a;
    logic [SA_W-1:0]             slot_ra_b;
    logic                        pos_we;
    logic [PA_W-1:0]             pos_wa;
    logic [PV_W-1:0]             pos_wd;
    logic [PA_W-1:0]             pos_ra;

    logic [PV_W-1:0]             n_w;
    logic [PV_W-1:0]             k_w;
    logic [PV_W-1:0]             bnd;
    logic [PV_W-1:0]             lim;
    logic                        halve;

    // bound on the first position of pair k; halved on the mirror pair
    always_comb begin
        n_w   = PV_W'(r_n);
        k_w   = PV_W'(r_k);
        bnd   = (n_w << 1) - PV_W'(1) - k_w;
        halve = (!r_n[0] && (k_w == n_w - PV_W'(1))) || (r_n[0] && (k_w == n_w));
        lim   = halve ? (bnd >> 1) : bnd;
    end

    always_comb begin
        slot_we   = 1'b0;
        slot_wa   = SA_W'(r_p - PV_W'(1));
        slot_wd   = 1'b0;
        pos_we    = 1'b0;
        pos_wa    = PA_W'(r_k - LV_W'(1));
        pos_wd    = '0;
        slot_ra_a = SA_W'(r_p - PV_W'(1));
        slot_ra_b = SA_W'(r_p + k_w);
        pos_ra    = PA_W'(r_level - LV_W'(1));
        unique case (r_state)
            S_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = r_clr;
                pos_we  = (32'(r_clr) < MAX_PAIRS);
                pos_wa  = PA_W'(r_clr);
            end
            S_PUT_A: begin
                slot_we = 1'b1;
                slot_wd = 1'b1;
            end
            S_PUT_B: begin
                slot_we = 1'b1;
                slot_wa = SA_W'(r_p + k_w);
                slot_wd = 1'b1;
                pos_we  = 1'b1;
                pos_wd  = r_p;
            end
            S_LIFT_A: begin
                slot_we = 1'b1;
                slot_wa = SA_W'(r_q - PV_W'(1));
            end
            S_LIFT_B: begin
                slot_we = 1'b1;
                slot_wa = SA_W'(r_q + k_w);
                pos_we  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_wa] <= slot_wd;
        end
        if (pos_we) begin
            r_pos_mem[pos_wa] <= pos_wd;
        end
        r_slot_rd_a <= r_slot_mem[slot_ra_a];
        r_slot_rd_b <= r_slot_mem[slot_ra_b];
        r_pos_rd    <= r_pos_mem[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rej       <= 1'b0;
            r_cnt       <= '0;
            r_in_search <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n      <= i_task.n;
                        r_pos_in <= i_task.pos;
                        r_top    <= LV_W'(i_task.n) - LV_W'(DEPTH);
                        r_clr    <= '0;
                        r_cnt    <= '0;
                        r_rej    <= 1'b0;
                        r_state  <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (r_clr == SA_W'(SLOTS - 1)) begin
                        r_idx   <= '0;
                        r_k     <= LV_W'(r_n);
                        r_p     <= PV_W'(r_pos_in[0]);
                        r_state <= S_PF_RD;
                    end else begin
                        r_clr <= r_clr + SA_W'(1);
                    end
                end
                S_PF_RD: begin
                    if (r_p == '0 || r_p > lim) begin
                        r_rej   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_PF_CHK;
                    end
                end
                S_PF_CHK: begin
                    if (r_slot_rd_a || r_slot_rd_b) begin
                        r_rej   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_in_search <= 1'b0;
                        r_state     <= S_PUT_A;
                    end
                end
                S_PUT_A: begin
                    r_state <= S_PUT_B;
                end
                S_PUT_B: begin
                    if (r_in_search) begin
                        r_level <= r_level - LV_W'(1);
                        r_state <= S_LVL;
                    end else if (r_idx == PFX_IDX_W'(DEPTH - 1)) begin
                        r_level <= r_top;
                        r_state <= S_LVL;
                    end else begin
                        r_idx   <= r_idx + PFX_IDX_W'(1);
                        r_k     <= r_k - LV_W'(1);
                        r_p     <= PV_W'(r_pos_in[r_idx + PFX_IDX_W'(1)]);
                        r_state <= S_PF_RD;
                    end
                end
                S_LVL: begin
                    if (r_level == '0 || r_level > r_top) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_level;
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_q <= r_pos_rd;
                    if (r_pos_rd != '0) begin
                        r_p     <= r_pos_rd + PV_W'(1);
                        r_state <= S_LIFT_A;
                    end else begin
                        r_p     <= PV_W'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_LIFT_A: begin
                    r_state <= S_LIFT_B;
                end
                S_LIFT_B: begin
                    r_state <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    if (r_p > lim) begin
                        r_level <= r_level + LV_W'(1);
                        r_state <= S_LVL;
                    end else begin
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (!r_slot_rd_a && !r_slot_rd_b) begin
                        if (r_k == LV_W'(1)) begin
                            // last pair fits: count it; place and lift cancel out
                            if (r_cnt != '1) begin
                                r_cnt <= r_cnt + COUNT_W'(1);
                            end
                            r_level <= r_level + LV_W'(1);
                            r_state <= S_LVL;
                        end else begin
                            r_in_search <= 1'b1;
                            r_state     <= S_PUT_A;
                        end
                    end else begin
                        r_p     <= r_p + PV_W'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle            = (r_state == S_IDLE);
    assign o_done            = (r_state == S_DONE) && i_res_ready;
    assign o_result.count    = r_rej ? '0 : r_cnt;
    assign o_result.rejected = r_rej;

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS) |-> (r_level != '0 && r_level <= r_top && r_k == r_level))
        else $error("search level out of range at position read");

    a_scan_within_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> (r_p != '0 && r_p <= lim))
        else $error("scan candidate beyond bound");

    a_place_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT_A) |-> ($past(r_state) == S_PF_CHK || $past(r_state) == S_SCAN_CHK))
        else $error("pair placed without a free-slot check");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_result.rejected || o_result.count == '0))
        else $error("rejected prefix with nonzero count");

endmodule

`default_nettype wire

// ===== sv/langford_pairing_counter.sv =====
// Top level of the Langford pairing counter: config register, task intake,
// result register. Depends on lpc_pkg, the lpc_*_if interfaces, lpc_engine.
//
//  channel  | dir | payload                                         | transfer when
//  ---------+-----+-------------------------------------------------+---------------------
//  i_cfg    | in  | pair_count[4:0]                                 | valid & ready
//  i_in     | in  | top_pair_pos, second_pair_pos, third_pair_pos   | valid & ready
//  o_out    | out | solution_count[31:0], prefix_rejected           | valid & ready
//
// One task at a time. A task first sweeps all 2*MAX_PAIRS slot memory entries,
// then places the prefix pairs, each bound-checked, slot-checked and written.
// The search scans candidate positions, enters levels, lifts and places pairs;
// each lift or placement writes two slots through the single write port of
// the slot memory. i_in.ready is high whenever the engine is idle, even while
// a result waits in o_out. Config is always ready. Synchronous active-low reset;
// the memories are not reset since every task sweeps them before use.
`default_nettype none

module langford_pairing_counter import lpc_pkg::*; #(
    parameter int MAX_PAIRS    = DEF_MAX_PAIRS,
    parameter int PREFIX_PAIRS = DEF_PREFIX_PAIRS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpc_cfg_if.sink    i_cfg,
    lpc_in_if.sink     i_in,
    lpc_out_if.source  o_out
);

    logic [NCFG_W-1:0] r_pair_count;
    logic              r_out_valid;
    t_result           r_out;

    logic              eng_idle;
    logic              eng_done;
    logic              res_ready;
    logic              start;
    t_task             task_in;
    t_result           eng_result;
    logic [NCFG_W-1:0] n_clamped;

    // config register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= PAIR_COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_pair_count <= i_cfg.pair_count;
        end
    end

    // n is clamped to 4..MAX_PAIRS
    always_comb begin
        priority if (r_pair_count < PAIR_COUNT_MIN) begin
            n_clamped = PAIR_COUNT_MIN;
        end else if (32'(r_pair_count) > MAX_PAIRS) begin
            n_clamped = NCFG_W'(MAX_PAIRS);
        end else begin
            n_clamped = r_pair_count;
        end
    end

    assign task_in.n      = n_clamped;
    assign task_in.pos[0] = i_in.top_pair_pos;
    assign task_in.pos[1] = i_in.second_pair_pos;
    assign task_in.pos[2] = i_in.third_pair_pos;

    assign i_in.ready = eng_idle;
    assign start      = i_in.valid && eng_idle;

    // result register decouples the engine from the output stall
    assign res_ready = !r_out_valid || o_out.ready;

    lpc_engine #(
        .MAX_PAIRS    (MAX_PAIRS),
        .PREFIX_PAIRS (PREFIX_PAIRS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_task      (task_in),
        .o_idle      (eng_idle),
        .i_res_ready (res_ready),
        .o_done      (eng_done),
        .o_result    (eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_out <= eng_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.solution_count  = r_out.count;
    assign o_out.prefix_rejected = r_out.rejected;

endmodule

`default_nettype wire
